[hw/rtl/orc_pkg.sv]
package orc_pkg;

  // Field widths
  localparam int START_BITS = 48;
  localparam int COUNT_BITS = 48;
  localparam int CNT_W      = 31;
  localparam int NEXT_W     = ((START_BITS > COUNT_BITS) ? START_BITS : COUNT_BITS) + 1;
  localparam int SUM_W      = COUNT_BITS + 1;

  // Largest value of a 31-bit counter, also the signed 32-bit maximum
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Result queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT           = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_UNBOUNDED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PRESENT   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK,
    ST_START_NA,
    ST_START_LOW,
    ST_NOT_ASCENDING,
    ST_BEYOND_EXTENT,
    ST_COUNT_NA,
    ST_COUNT_NEGATIVE,
    ST_TOO_LARGE
  } orc_status_t;

  typedef struct packed {
    logic [START_BITS-1:0]        start_value;
    logic                         start_is_na;
    logic signed [COUNT_BITS-1:0] count_value;
    logic                         count_is_na;
    logic                         is_last;
  } orc_in_t;

  typedef struct packed {
    orc_status_t           status;
    logic [START_BITS-1:0] block_start;
    logic [CNT_W-1:0]      block_length;
    logic                  run_end;
    logic [CNT_W-1:0]      selected_total;
    logic [CNT_W-1:0]      element_total;
    logic [CNT_W-1:0]      block_total;
    logic                  can_reduce;
  } orc_out_t;

  typedef struct packed {
    logic [START_BITS-1:0] extent;
    logic                  extent_unbounded;
    logic                  counts_present;
  } orc_cfg_t;

  // Results produced by one item: cnt is 0, 1 or 2, a goes out first
  typedef struct packed {
    logic [1:0] cnt;
    orc_out_t   a;
    orc_out_t   b;
  } orc_push_t;

endpackage

[hw/rtl/orc_engine.sv]
module orc_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  orc_pkg::orc_in_t  in_data,
  input  orc_pkg::orc_cfg_t cfg,
  input  logic              room2,
  output orc_pkg::orc_push_t push
);
  import orc_pkg::*;

  // Input register
  logic    in_v_r;
  orc_in_t in_r;
  logic    take;

  assign take     = in_v_r && room2;
  assign in_ready = !in_v_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // List state
  logic [NEXT_W-1:0]     nes_r, nes_nxt;
  logic [START_BITS-1:0] open_start_r, open_start_nxt;
  logic [CNT_W-1:0]      open_len_r, open_len_nxt;
  logic                  open_r, open_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      pairs_r, pairs_nxt;
  logic [CNT_W-1:0]      blocks_r, blocks_nxt;
  logic                  err_r, err_nxt;

  // Datapath terms for the item in the input register
  logic [COUNT_BITS-1:0] cnt;
  logic                  skip;
  logic [NEXT_W-1:0]     start_ext;
  logic [NEXT_W-1:0]     next_start;
  logic [NEXT_W-1:0]     extent_ext;
  logic [SUM_W-1:0]      sum;
  logic                  new_block;
  logic                  fail;
  orc_status_t           fail_code;
  orc_out_t              closed_rec;
  orc_out_t              final_rec;
  orc_out_t              err_rec;

  assign cnt        = cfg.counts_present ? COUNT_BITS'(unsigned'(in_r.count_value))
                                         : COUNT_BITS'(1);
  assign skip       = cfg.counts_present && (in_r.count_value == '0);
  assign start_ext  = NEXT_W'(in_r.start_value);
  assign next_start = start_ext + NEXT_W'(cnt);
  assign extent_ext = NEXT_W'(cfg.extent);
  assign sum        = SUM_W'(total_r) + SUM_W'(cnt);
  assign new_block  = !open_r || (start_ext != nes_r);

  // Checks in priority order
  always_comb begin
    fail      = 1'b1;
    fail_code = ST_OK;
    if (cfg.counts_present && in_r.count_is_na) begin
      fail_code = ST_COUNT_NA;
    end else if (cfg.counts_present && in_r.count_value[COUNT_BITS-1]) begin
      fail_code = ST_COUNT_NEGATIVE;
    end else if (skip) begin
      fail = 1'b0;
    end else if (in_r.start_is_na) begin
      fail_code = ST_START_NA;
    end else if (in_r.start_value == '0) begin
      fail_code = ST_START_LOW;
    end else if (start_ext < nes_r) begin
      fail_code = ST_NOT_ASCENDING;
    end else if (!cfg.extent_unbounded && ((next_start - NEXT_W'(1)) > extent_ext)) begin
      fail_code = ST_BEYOND_EXTENT;
    end else if (sum > SUM_W'(CNT_MAX)) begin
      fail_code = ST_TOO_LARGE;
    end else begin
      fail = 1'b0;
    end
  end

  // Next state and result items
  always_comb begin
    nes_nxt        = nes_r;
    open_start_nxt = open_start_r;
    open_len_nxt   = open_len_r;
    open_nxt       = open_r;
    total_nxt      = total_r;
    pairs_nxt      = pairs_r;
    blocks_nxt     = blocks_r;
    err_nxt        = err_r;
    push           = '0;
    closed_rec     = '0;
    final_rec      = '0;
    err_rec        = '0;

    if (take) begin
      if (err_r) begin
        // Drain the rest of a failed list, its last pair clears the list state
        if (in_r.is_last) begin
          err_nxt        = 1'b0;
          nes_nxt        = '0;
          open_start_nxt = '0;
          open_len_nxt   = '0;
          open_nxt       = 1'b0;
          total_nxt      = '0;
          pairs_nxt      = '0;
          blocks_nxt     = '0;
        end
      end else begin
        if (pairs_r != CNT_MAX) begin
          pairs_nxt = pairs_r + CNT_W'(1);
        end
        if (fail) begin
          err_rec.status  = fail_code;
          err_rec.run_end = 1'b1;
          push.cnt        = 2'd1;
          push.a          = err_rec;
          err_nxt         = !in_r.is_last;
        end else begin
          if (!skip) begin
            total_nxt = CNT_W'(sum);
            nes_nxt   = next_start;
            if (new_block) begin
              if (blocks_r != CNT_MAX) begin
                blocks_nxt = blocks_r + CNT_W'(1);
              end
              open_start_nxt = in_r.start_value;
              open_len_nxt   = CNT_W'(cnt);
              open_nxt       = 1'b1;
            end else begin
              open_len_nxt = open_len_r + CNT_W'(cnt);
            end
          end

          // Block closed by a start that does not continue it
          closed_rec.status         = ST_OK;
          closed_rec.block_start    = open_start_r;
          closed_rec.block_length   = open_len_r;
          closed_rec.selected_total = total_nxt;
          closed_rec.element_total  = pairs_nxt;
          closed_rec.block_total    = blocks_nxt;

          final_rec.status         = ST_OK;
          final_rec.block_start    = open_nxt ? open_start_nxt : '0;
          final_rec.block_length   = open_nxt ? open_len_nxt : '0;
          final_rec.run_end        = 1'b1;
          final_rec.selected_total = total_nxt;
          final_rec.element_total  = pairs_nxt;
          final_rec.block_total    = blocks_nxt;
          final_rec.can_reduce     = blocks_nxt < pairs_nxt;

          if (!skip && new_block && open_r) begin
            push.a   = closed_rec;
            push.b   = final_rec;
            push.cnt = in_r.is_last ? 2'd2 : 2'd1;
          end else if (in_r.is_last) begin
            push.a   = final_rec;
            push.cnt = 2'd1;
          end
        end

        // End of list returns everything to its reset value
        if (in_r.is_last) begin
          nes_nxt        = '0;
          open_start_nxt = '0;
          open_len_nxt   = '0;
          open_nxt       = 1'b0;
          total_nxt      = '0;
          pairs_nxt      = '0;
          blocks_nxt     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nes_r        <= '0;
      open_start_r <= '0;
      open_len_r   <= '0;
      open_r       <= 1'b0;
      total_r      <= '0;
      pairs_r      <= '0;
      blocks_r     <= '0;
      err_r        <= 1'b0;
    end else begin
      nes_r        <= nes_nxt;
      open_start_r <= open_start_nxt;
      open_len_r   <= open_len_nxt;
      open_r       <= open_nxt;
      total_r      <= total_nxt;
      pairs_r      <= pairs_nxt;
      blocks_r     <= blocks_nxt;
      err_r        <= err_nxt;
    end
  end

  // Two results only when a closed block is followed by the final one
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.b.run_end && !push.a.run_end))
    else $error("two results without a closed block and a final block");

  // An error item gives exactly one result, and it ends the list
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    ((push.cnt != 2'd0) && (push.a.status != ST_OK)) |-> ((push.cnt == 2'd1) && push.a.run_end))
    else $error("error result not alone or without run_end");

endmodule

[hw/rtl/orc_out_queue.sv]
module orc_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  orc_pkg::orc_push_t push,
  output logic               room2,
  output logic               out_valid,
  input  logic               out_ready,
  output orc_pkg::orc_out_t  out_data
);
  import orc_pkg::*;

  orc_out_t          mem [QDEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[head_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= QCNT_W'(QDEPTH - 2));

  // Pointer and fill bookkeeping
  always_comb begin
    head_nxt  = head_r + QPTR_W'(pop);
    tail_nxt  = tail_r + QPTR_W'(push.cnt);
    count_nxt = count_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Up to two entries written per item
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[tail_r] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      mem[tail_r + QPTR_W'(1)] <= push.b;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) + QCNT_W'($past(push.cnt)) - QCNT_W'($past(pop))))
    else $error("result queue fill count out of step");

endmodule

[hw/rtl/ordered_run_coalescer_core.sv]
// Ordered run coalescer: takes one (start, count) pair of a sorted selection list
// per input item, checks it, merges pairs that continue the open block, and emits
// each closed block plus a final block with totals when is_last is seen. The first
// error gives one result with run_end set; the rest of that list is dropped up to
// and including its last pair. Rate: one input item per cycle sustained as long as
// the result side takes one result per cycle. An item is held in an input register
// while check-and-merge logic works on it; its results are written into a 4-entry
// result queue, from which they are read. The input stalls while
// the queue has fewer than two free entries; a last pair that closes a block yields
// two results. Configuration is taken every cycle and must only change while idle.
module ordered_run_coalescer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  orc_pkg::orc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output orc_pkg::orc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [orc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [orc_pkg::START_BITS-1:0]    cfg_data
);
  import orc_pkg::*;

  // Configuration registers
  orc_cfg_t cfg_r;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.extent           <= '0;
      cfg_r.extent_unbounded <= 1'b1;
      cfg_r.counts_present   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXTENT:           cfg_r.extent           <= cfg_data;
        CFG_EXTENT_UNBOUNDED: cfg_r.extent_unbounded <= cfg_data[0];
        CFG_COUNTS_PRESENT:   cfg_r.counts_present   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Check and merge stage
  orc_push_t push;
  logic      room2;

  orc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .room2    (room2),
    .push     (push)
  );

  // Result queue
  orc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
